/* rtl/core/ppghb_pkg.sv */
`default_nettype none
package ppghb_pkg;

  localparam int DefRingDepth = 32;
  localparam int DataW        = 16;
  localparam int AccW         = 32;
  localparam int WeightW      = 13;
  localparam int HalfTaps     = 11;
  localparam int TapSpan      = 22;
  localparam int StepW        = 4;
  localparam int CfgIdxW      = 2;

  localparam logic [CfgIdxW-1:0] CFG_MIN_P2P    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_P2P    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REFRACTORY = 2'd2;

  localparam logic [DataW-1:0] MIN_P2P_RST     = 16'd20;
  localparam logic [DataW-1:0] MAX_P2P_RST     = 16'd1000;
  localparam logic [DataW-1:0] REFRACTORY_RST  = 16'd25;
  localparam logic [DataW-1:0] LATCHED_MAX_RST = 16'd20;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] ac;
  } fir_status_t;

  function automatic logic [WeightW-1:0] fir_weight(input logic [StepW-1:0] k);
    logic [WeightW-1:0] w;
    unique case (k)
      4'd0:    w = 13'd172;
      4'd1:    w = 13'd321;
      4'd2:    w = 13'd579;
      4'd3:    w = 13'd927;
      4'd4:    w = 13'd1360;
      4'd5:    w = 13'd1858;
      4'd6:    w = 13'd2390;
      4'd7:    w = 13'd2916;
      4'd8:    w = 13'd3391;
      4'd9:    w = 13'd3768;
      4'd10:   w = 13'd4012;
      4'd11:   w = 13'd4096;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ppghb_in_if.sv */
`default_nettype none
interface ppghb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* rtl/core/ppghb_out_if.sv */
`default_nettype none
interface ppghb_out_if;
  logic               valid;
  logic               ready;
  logic               beat;
  logic signed [15:0] ac_signal;
  logic        [15:0] dc_estimate;

  modport source (output valid, output beat, output ac_signal, output dc_estimate,
                  input ready);
  modport sink (input valid, input beat, input ac_signal, input dc_estimate,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/ppghb_fir.sv */
`default_nettype none
module ppghb_fir #(
  parameter int RING_DEPTH = ppghb_pkg::DefRingDepth
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [ppghb_pkg::DataW-1:0] diff,
  output ppghb_pkg::fir_status_t                  status
);
  import ppghb_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW:0]      DEPTH_W = (PW+1)'(RING_DEPTH);
  localparam logic [StepW-1:0] LAST_K  = StepW'(HalfTaps);
  localparam logic [StepW:0]   SPAN    = (StepW+1)'(TapSpan);

  logic signed [DataW-1:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0]   vld;
  logic [PW-1:0]           pos;

  logic                    run;
  logic [StepW-1:0]        k;
  logic [PW-1:0]           addr_a, addr_b;
  logic [StepW:0]          back_b;

  logic                    r1_vld, r1_va, r1_vb;
  logic [StepW-1:0]        r1_k;
  logic signed [DataW-1:0] rd_a, rd_b;

  logic                    r2_vld, r2_last;
  logic signed [DataW+WeightW:0] prod;
  logic signed [DataW-1:0] pair;
  logic signed [AccW-1:0]  z;
  logic                    done;

  function automatic logic [PW-1:0] back_addr(input logic [PW-1:0] p,
                                               input logic [StepW:0] b);
    logic [PW:0] pe, be;
    pe = {1'b0, p};
    be = (PW+1)'(b);
    if (pe >= be) begin
      return PW'(pe - be);
    end else begin
      return PW'(pe + DEPTH_W - be);
    end
  endfunction

  assign back_b = SPAN - {1'b0, k};
  assign addr_a = back_addr(pos, {1'b0, k});
  assign addr_b = back_addr(pos, back_b);

  always_ff @(posedge clk) begin
    if (start) begin
      ring[pos] <= diff;
    end
    rd_a <= ring[addr_a];
    rd_b <= ring[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      pos    <= '0;
      run    <= 1'b0;
      k      <= '0;
      r1_vld <= 1'b0;
      r2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      if (start) begin
        vld[pos] <= 1'b1;
        run      <= 1'b1;
        k        <= '0;
      end else if (run) begin
        k <= k + StepW'(1);
        if (k == LAST_K) begin
          run <= 1'b0;
        end
      end
      r1_vld <= run;
      r2_vld <= r1_vld;
      done   <= r2_vld && r2_last;
      if (done) begin
        pos <= (pos == PW'(RING_DEPTH - 1)) ? '0 : pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    r1_k  <= k;
    r1_va <= vld[addr_a];
    r1_vb <= vld[addr_b] && (k != LAST_K);
  end

  assign pair = (r1_va ? rd_a : '0) + (r1_vb ? rd_b : '0);

  always_ff @(posedge clk) begin
    prod    <= pair * $signed({1'b0, fir_weight(r1_k)});
    r2_last <= (r1_k == LAST_K);
    if (start) begin
      z <= '0;
    end else if (r2_vld) begin
      z <= z + AccW'(prod);
    end
  end

  assign status.done = done;
  assign status.ac   = z[30:15];

endmodule
`default_nettype wire

/* rtl/core/ppg_heartbeat_detector.sv */
// Each accepted sample passes the ACC, WR, FIR and FINAL states before its result
// is offered; no sample is taken before then. The FIR pass runs twelve coefficient
// steps through the two read ports of the difference ring.
// The next sample is taken while a finished result still waits downstream.
// Reset (synchronous, rst high) clears the control state and ring valid bits, so ring
// entries read as zero until written; the registers return to 20, 1000 and 25.
`default_nettype none
module ppg_heartbeat_detector #(
  parameter int RING_DEPTH = ppghb_pkg::DefRingDepth
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  ppghb_in_if.sink                                  samples,
  ppghb_out_if.source                               results,
  input  wire logic                                 cfg_write,
  input  wire logic [ppghb_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [ppghb_pkg::DataW-1:0]          cfg_data
);
  import ppghb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_FIR   = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state, state_next;

  logic [DataW-1:0] min_p2p, max_p2p, refr_samples;

  logic [DataW-1:0]        x;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW:0]    acc_diff;
  logic signed [DataW-1:0] ring_diff;

  logic signed [DataW-1:0] cur_ac, phase_max, phase_min, latched_max;
  logic                    rising_phase, falling_phase;
  logic [DataW-1:0]        refr;

  logic                    out_vld, out_beat;
  logic signed [DataW-1:0] out_ac;
  logic [DataW-1:0]        out_dc;

  fir_status_t fir_st;
  logic        fir_start, finish;

  logic signed [DataW-1:0] ac_new, pmax_n, pmin_n, lmax_n;
  logic                    rise, fall, rph_n, fph_n, beat_n;
  logic [DataW-1:0]        refr_dec, refr_n;
  logic signed [DataW+1:0] p2p;

  ppghb_fir #(.RING_DEPTH(RING_DEPTH)) u_fir (
    .clk    (clk),
    .rst    (rst),
    .start  (fir_start),
    .diff   (ring_diff),
    .status (fir_st)
  );

  assign samples.ready = (state == S_IDLE);
  assign fir_start     = (state == S_WR);
  assign finish        = (state == S_FINAL) && (!out_vld || results.ready);

  assign acc_diff  = $signed({2'b00, x, 15'd0}) - (AccW+1)'(acc);
  assign ring_diff = x - acc[30:15];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (samples.valid) state_next = S_ACC;
      S_ACC:   state_next = S_WR;
      S_WR:    state_next = S_FIR;
      S_FIR:   if (fir_st.done) state_next = S_FINAL;
      S_FINAL: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ac_new   = fir_st.ac;
    rise     = cur_ac[DataW-1] && !ac_new[DataW-1];
    fall     = !cur_ac[DataW-1] && (cur_ac != '0) && (ac_new[DataW-1] || ac_new == '0);
    refr_dec = (refr != '0) ? refr - DataW'(1) : refr;
    lmax_n   = rise ? phase_max : latched_max;
    pmax_n   = rise ? '0 : phase_max;
    pmin_n   = fall ? '0 : phase_min;
    rph_n    = rise ? 1'b1 : (fall ? 1'b0 : rising_phase);
    fph_n    = rise ? 1'b0 : (fall ? 1'b1 : falling_phase);
    p2p      = (DataW+2)'(lmax_n) - (DataW+2)'(phase_min);
    beat_n   = rise && (p2p > $signed({2'b00, min_p2p}))
                    && (p2p < $signed({2'b00, max_p2p})) && (refr_dec == '0);
    refr_n   = beat_n ? refr_samples : refr_dec;
    if (rph_n && (ac_new > cur_ac)) pmax_n = ac_new;
    if (fph_n && (ac_new < cur_ac)) pmin_n = ac_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_p2p      <= MIN_P2P_RST;
      max_p2p      <= MAX_P2P_RST;
      refr_samples <= REFRACTORY_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MIN_P2P:    min_p2p      <= cfg_data;
        CFG_MAX_P2P:    max_p2p      <= cfg_data;
        CFG_REFRACTORY: refr_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      x <= samples.sample;
    end
    if (finish) begin
      out_beat <= beat_n;
      out_ac   <= ac_new;
      out_dc   <= acc[30:15];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      acc           <= '0;
      cur_ac        <= '0;
      phase_max     <= '0;
      phase_min     <= '0;
      latched_max   <= LATCHED_MAX_RST;
      rising_phase  <= 1'b0;
      falling_phase <= 1'b0;
      refr          <= '0;
      out_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ACC) begin
        acc <= acc + AccW'(acc_diff >>> 4);
      end
      if (finish) begin
        cur_ac        <= ac_new;
        phase_max     <= pmax_n;
        phase_min     <= pmin_n;
        latched_max   <= lmax_n;
        rising_phase  <= rph_n;
        falling_phase <= fph_n;
        refr          <= refr_n;
        out_vld       <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign results.valid       = out_vld;
  assign results.beat        = out_beat;
  assign results.ac_signal   = out_ac;
  assign results.dc_estimate = out_dc;

endmodule
`default_nettype wire
